// ----- rtl/core/fwta_pkg.sv -----
package fwta_pkg;

   // Window geometry
   localparam int WINDOW = 8;
   localparam int SMP_W = 12;
   localparam int OUT_CNT_W = 4;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = SMP_W + $clog2(WINDOW);
   localparam int QUO_W = SUM_W - 1;
   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int DIV_CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

   // Control and status register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMIT = 1'd1;

   // Limit reset values, 1/16 degree units
   localparam logic signed [SMP_W-1:0] LOW_LIMIT_RESET = -12'sd640;
   localparam logic signed [SMP_W-1:0] HIGH_LIMIT_RESET = 12'sd960;

   typedef logic signed [SMP_W-1:0] temp_type;
   typedef logic [OUT_CNT_W-1:0] out_count_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_DIV,
      ST_DELIVER
   } state_type;

   // Sequencer to window control
   typedef struct packed {
      logic load;
      logic step;
   } win_ctl_type;

   // Clamp the true count to the width of the result field
   function automatic out_count_type sat_count(input logic [CNT_W-1:0] count);
      logic [CNT_W+OUT_CNT_W-1:0] wide;
      wide = (CNT_W + OUT_CNT_W)'(count);
      if (wide > (CNT_W + OUT_CNT_W)'((1 << OUT_CNT_W) - 1)) begin
         sat_count = '1;
      end else begin
         sat_count = wide[OUT_CNT_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/core/fwta_if.sv -----
interface fwta_req_if;
   logic valid;
   logic ready;
   fwta_pkg::temp_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface fwta_rsp_if;
   logic valid;
   logic ready;
   fwta_pkg::temp_type mean_temp;
   fwta_pkg::out_count_type valid_count;

   modport source (output valid, output mean_temp, output valid_count, input ready);
   modport sink (input valid, input mean_temp, input valid_count, output ready);
endinterface

interface fwta_csr_if;
   logic valid;
   logic ready;
   fwta_pkg::csr_index_type index;
   fwta_pkg::temp_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/fwta_window.sv -----
module fwta_window (
   input  logic                        clock,
   input  logic                        reset,
   input  fwta_pkg::win_ctl_type       ctl,
   input  fwta_pkg::temp_type          sample,
   input  fwta_pkg::temp_type          low_limit,
   input  fwta_pkg::temp_type          high_limit,
   output logic signed [fwta_pkg::SUM_W-1:0] sum,
   output logic [fwta_pkg::CNT_W-1:0]  count,
   output logic                        last
);
   import fwta_pkg::*;

   temp_type win_ff [WINDOW];
   temp_type win_in [WINDOW];
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   temp_type tap;
   logic tap_ok;

   // Oldest entry sits at the tail; a scan step rotates it back to the head
   assign tap = win_ff[WINDOW-1];
   assign tap_ok = (tap != '0) && (tap > low_limit) && (tap < high_limit);
   assign last = (idx_ff == IDX_W'(WINDOW - 1));

   // Shift line: load takes the new sample, step recirculates the tail
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctl.load || ctl.step) begin
         for (int i = 1; i < WINDOW; i++) begin
            win_in[i] = win_ff[i-1];
         end
         win_in[0] = ctl.load ? sample : tap;
      end
   end

   // Shared accumulate unit, one entry per step
   always_comb begin
      sum_in = sum_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      if (ctl.load) begin
         sum_in = '0;
         count_in = '0;
         idx_in = '0;
      end else if (ctl.step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (tap_ok) begin
            sum_in = sum_ff + SUM_W'(tap);
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         idx_ff <= '0;
      end else begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= win_in[i];
         end
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      count_ff <= count_in;
   end

   assign sum = sum_ff;
   assign count = count_ff;

endmodule

// ----- rtl/core/fwta_div.sv -----
module fwta_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fwta_pkg::QUO_W-1:0]  dividend,
   input  logic [fwta_pkg::CNT_W-1:0]  divisor,
   output logic                        busy,
   output logic [fwta_pkg::QUO_W-1:0]  quotient
);
   import fwta_pkg::*;

   logic busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dsr_ff, dsr_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W:0] trial;
   logic [CNT_W:0] diff;

   // Restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         dsr_in = divisor;
         quo_in = dividend;
      end else if (busy_ff) begin
         step_in = step_ff + DIV_CNT_W'(1);
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         if (step_ff == DIV_CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/filtered_window_temperature_average.sv -----
// Channel   Role      Payload                        Transaction when
// req_ch    sink      sample                         valid && ready
// rsp_ch    source    mean_temp, valid_count         valid && ready
// csr_ch    sink      index, data (limit registers)  valid && ready, ready always high
//
// One sample passes through accept, scan, evaluate and deliver, with the serial
// divider run between evaluate and deliver when the valid sum is positive. The
// window scan uses one shared compare/add unit; the divider does one quotient bit
// per cycle. req_ch is ready only while the sequencer is idle.
// The result sits in an output register, so a new sample can be taken while rsp_ch
// is stalled; a second result waits in deliver until that register frees up.
// Synchronous reset clears the window and loads default limits.
module filtered_window_temperature_average (
   input  logic            clock,
   input  logic            reset,
   fwta_req_if.sink        req_ch,
   fwta_rsp_if.source      rsp_ch,
   fwta_csr_if.sink        csr_ch
);
   import fwta_pkg::*;

   state_type state_ff, state_in;
   temp_type low_ff, low_in;
   temp_type high_ff, high_in;
   logic rsp_valid_ff, rsp_valid_in;
   temp_type mean_ff, mean_in;
   out_count_type cnt_ff, cnt_in;

   win_ctl_type win_ctl;
   logic signed [SUM_W-1:0] win_sum;
   logic [CNT_W-1:0] win_count;
   logic win_last;
   logic div_start;
   logic div_busy;
   logic [QUO_W-1:0] div_quo;
   logic sum_pos;
   logic slot_free;
   logic out_load;

   fwta_window u_window (
      .clock      (clock),
      .reset      (reset),
      .ctl        (win_ctl),
      .sample     (req_ch.sample),
      .low_limit  (low_ff),
      .high_limit (high_ff),
      .sum        (win_sum),
      .count      (win_count),
      .last       (win_last)
   );

   fwta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_sum[QUO_W-1:0]),
      .divisor  (win_count),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Positive: sign bit clear and not zero
   assign sum_pos = !win_sum[SUM_W-1] && (win_sum != '0);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // Limit registers
   assign csr_ch.ready = 1'b1;
   always_comb begin
      low_in = low_ff;
      high_in = high_ff;
      if (csr_ch.valid) begin
         if (csr_ch.index == CSR_LOW_LIMIT) begin
            low_in = csr_ch.data;
         end
         if (csr_ch.index == CSR_HIGH_LIMIT) begin
            high_in = csr_ch.data;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      win_ctl = '0;
      div_start = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               win_ctl.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            win_ctl.step = 1'b1;
            if (win_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sum_pos) begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (slot_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      mean_in = mean_ff;
      cnt_in = cnt_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         mean_in = sum_pos ? SMP_W'(div_quo) : '0;
         cnt_in = sat_count(win_count);
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         low_ff <= LOW_LIMIT_RESET;
         high_ff <= HIGH_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         low_ff <= low_in;
         high_ff <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.mean_temp = mean_ff;
   assign rsp_ch.valid_count = cnt_ff;

endmodule
